// File: rtl/drrip_cache_replacement_macros.svh
// assertion macros shared by the drrip checker
// no dependencies; pulled in by files that hold concurrent assertions
`ifndef DRRIP_CACHE_REPLACEMENT_MACROS_SVH
`define DRRIP_CACHE_REPLACEMENT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define DRRIP_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define DRRIP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/drrip_pkg.sv
// shared types, codes and default sizes for the drrip replacement block
// no dependencies; used by every other file of the block except the macros header
`default_nettype none

package drrip_pkg;

   localparam int SETS_DEFAULT          = 2048;
   localparam int WAYS_DEFAULT          = 16;
   localparam int LEADERS_DEFAULT       = 32;
   localparam int SELECTOR_BITS_DEFAULT = 10;
   localparam int RRPV_MAX_DEFAULT      = 3;

   localparam int CMD_W       = 2;
   localparam int SET_INDEX_W = 11;
   localparam int WAY_INDEX_W = 4;
   localparam int MASK_W      = 16;
   localparam int BIMODAL_W   = 8;
   localparam int PERIOD_W    = 9;
   localparam int DIV_STEPS   = PERIOD_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd2;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd32;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 9'd256;

   typedef struct packed {
      logic [CMD_W-1:0]       cmd;
      logic [SET_INDEX_W-1:0] set_index;
      logic [WAY_INDEX_W-1:0] way_index;
      logic [MASK_W-1:0]      way_valid_mask;
      logic                   is_write;
      logic                   is_hit;
   } req_payload_type;

   typedef struct packed {
      logic [WAY_INDEX_W-1:0] victim_way;
      logic                   victim_was_invalid;
      logic                   followers_use_srrip;
   } rsp_payload_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic div_start;
      logic div_step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic need_div;
      logic div_last;
      logic out_busy;
   } ctrl_status_type;

endpackage

`default_nettype wire

// File: rtl/drrip_ctrl.sv
// sequencer for the drrip block: clearing pass, accept, execute, remainder steps
// depends on drrip_pkg; drives the datapath through ctrl_cmd_type
`default_nettype none

module drrip_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  drrip_pkg::ctrl_status_type status,
   output drrip_pkg::ctrl_cmd_type    cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;
   localparam logic [1:0] ST_DIV   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else if (!status.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_EXEC;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/drrip_datapath.sv
// set-row ram, rrpv aging and victim search, bimodal counters, selector, result register
// depends on drrip_pkg; sequenced by drrip_ctrl
`default_nettype none

module drrip_datapath #(
   parameter int SETS          = drrip_pkg::SETS_DEFAULT,
   parameter int WAYS          = drrip_pkg::WAYS_DEFAULT,
   parameter int LEADERS       = drrip_pkg::LEADERS_DEFAULT,
   parameter int SELECTOR_BITS = drrip_pkg::SELECTOR_BITS_DEFAULT,
   parameter int RRPV_MAX      = drrip_pkg::RRPV_MAX_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  drrip_pkg::req_payload_type          req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output drrip_pkg::rsp_payload_type          rsp_payload,
   input  logic                                csr_write_enable,
   input  logic [drrip_pkg::PERIOD_W-1:0]      csr_write_data,
   input  drrip_pkg::ctrl_cmd_type             cmd,
   output drrip_pkg::ctrl_status_type          status
);

   localparam int SET_W   = $clog2(SETS);
   localparam int RRPV_W  = $clog2(RRPV_MAX + 1);
   localparam int VALS_W  = WAYS * RRPV_W;
   localparam int ROW_W   = VALS_W + drrip_pkg::BIMODAL_W;
   localparam int SIW     = drrip_pkg::SET_INDEX_W;
   localparam int LW      = SIW + 1;
   localparam int PROD_W  = SIW + LW;
   localparam int PW      = drrip_pkg::PERIOD_W;
   localparam int STRIDE  = (SETS / LEADERS > 0) ? SETS / LEADERS : 1;
   // a set index never reaches the set space width, so larger strides act like it
   localparam int MOD_D   = (STRIDE > (1 << SIW)) ? (1 << SIW) : STRIDE;
   localparam int RECIP   = (1 << SIW) / MOD_D;

   localparam logic [LW-1:0]            D_C      = LW'(MOD_D);
   localparam logic [LW-1:0]            RECIP_C  = LW'(RECIP);
   localparam logic [31:0]              SETS_C   = 32'(SETS);
   localparam logic [31:0]              WAYS_C   = 32'(WAYS);
   localparam logic [RRPV_W-1:0]        MAX_V    = RRPV_W'(RRPV_MAX);
   localparam logic [RRPV_W-1:0]        NEAR_V   = RRPV_W'(RRPV_MAX - 1);
   localparam logic [SELECTOR_BITS-1:0] SEL_MID  = SELECTOR_BITS'(1) << (SELECTOR_BITS - 1);
   localparam logic [SELECTOR_BITS-1:0] SEL_TOP  = '1;
   localparam logic [ROW_W-1:0]         CLEAR_ROW = {{drrip_pkg::BIMODAL_W{1'b0}}, {WAYS{MAX_V}}};

   // set-row memory: rrpv of every way plus the bimodal counter
   logic [ROW_W-1:0] mem [SETS];

   logic [ROW_W-1:0]                    rd_row_ff;
   drrip_pkg::req_payload_type          req_ff;
   logic [SIW-1:0]                      q_ff;
   logic                                set_ok_ff;
   logic [SET_W-1:0]                    set_addr_ff;
   logic [SET_W-1:0]                    clr_cnt_ff;
   logic [SELECTOR_BITS-1:0]            sel_ff;
   logic [SELECTOR_BITS-1:0]            sel_in;
   logic [PW-1:0]                       period_ff;
   logic                                rsp_valid_ff;
   drrip_pkg::rsp_payload_type          rsp_payload_ff;
   drrip_pkg::rsp_payload_type          rsp_payload_in;
   logic                                div_valid_ff;
   logic [PW-1:0]                       div_rem_ff;
   logic [PW-1:0]                       div_rem_in;
   logic [PW-1:0]                       div_num_ff;
   logic [drrip_pkg::DIV_CNT_W-1:0]     div_cnt_ff;

   // accept-side signals
   logic [31:0]       req_set_wide;
   logic              rd_ok;
   logic [SET_W-1:0]  rd_addr;
   logic [PROD_W-1:0] prod;

   // execute-side signals
   logic [2*LW-1:0]          qd_full;
   logic [LW-1:0]            rem0;
   logic [LW-1:0]            rem;
   logic                     srrip_leader;
   logic                     brrip_leader;
   logic                     use_srrip;
   logic                     way_ok;
   logic [drrip_pkg::BIMODAL_W-1:0] cnt;
   logic [PW-1:0]            cnt_inc;
   logic [PW-1:0]            period_eff;
   logic [PW-1:0]            fast_rem;
   logic                     slow;
   logic [PW-1:0]            new_cnt_wide;
   logic [drrip_pkg::BIMODAL_W-1:0] new_cnt;
   logic [RRPV_W-1:0]        ins_val;
   logic                     fill_brrip;
   logic [RRPV_W-1:0]        vals [WAYS];
   logic [RRPV_W-1:0]        new_vals [WAYS];
   logic [RRPV_MAX:0]        present;
   logic [RRPV_W-1:0]        top;
   logic [WAYS-1:0]          at_top;
   logic [WAYS-1:0]          first_top;
   logic [WAYS-1:0]          inv;
   logic [WAYS-1:0]          first_inv;
   logic [31:0]              mask_wide;
   logic [drrip_pkg::WAY_INDEX_W-1:0] top_way;
   logic [drrip_pkg::WAY_INDEX_W-1:0] inv_way;
   logic [ROW_W-1:0]         new_row;
   logic                     mem_we;
   logic [SET_W-1:0]         mem_wa;
   logic [ROW_W-1:0]         mem_wd;
   logic [PW-1:0]            rem_shift;

   // ---------------- accept side ----------------
   always_comb begin
      req_set_wide = 32'(req_payload.set_index);
      rd_ok        = req_set_wide < SETS_C;
      rd_addr      = rd_ok ? req_set_wide[SET_W-1:0] : '0;
      // quotient estimate for the leader stride, low by at most one
      prod         = PROD_W'(req_payload.set_index) * PROD_W'(RECIP_C);
   end

   // ---------------- execute side ----------------
   always_comb begin
      qd_full      = (2*LW)'(q_ff) * (2*LW)'(D_C);
      rem0         = LW'(req_ff.set_index) - qd_full[LW-1:0];
      rem          = (rem0 >= D_C) ? rem0 - D_C : rem0;
      srrip_leader = (rem == '0);
      brrip_leader = (rem == LW'(1));
      use_srrip    = srrip_leader | (!brrip_leader & (sel_ff < SEL_MID));
      way_ok       = 32'(req_ff.way_index) < WAYS_C;
   end

   always_comb begin
      cnt        = rd_row_ff[ROW_W-1 -: drrip_pkg::BIMODAL_W];
      cnt_inc    = PW'(cnt) + PW'(1);
      if (period_ff == '0) begin
         period_eff = PW'(1);
      end else if (period_ff > drrip_pkg::PERIOD_MAX) begin
         period_eff = drrip_pkg::PERIOD_MAX;
      end else begin
         period_eff = period_ff;
      end
      fast_rem     = (cnt_inc < period_eff) ? cnt_inc : cnt_inc - period_eff;
      slow         = {1'b0, cnt_inc} >= {period_eff, 1'b0};
      new_cnt_wide = div_valid_ff ? div_rem_ff : fast_rem;
      new_cnt      = new_cnt_wide[drrip_pkg::BIMODAL_W-1:0];
      if (use_srrip) begin
         ins_val = NEAR_V;
      end else begin
         ins_val = (new_cnt == '0) ? NEAR_V : MAX_V;
      end
      fill_brrip = (req_ff.cmd == drrip_pkg::CMD_FILL) & set_ok_ff & way_ok
                   & !req_ff.is_write & !use_srrip;
   end

   // victim search: level presence, top value, lowest way at top, lowest invalid way
   always_comb begin
      present   = '0;
      top       = '0;
      top_way   = '0;
      inv_way   = '0;
      mask_wide = {{(32 - drrip_pkg::MASK_W){1'b1}}, req_ff.way_valid_mask};
      for (int w = 0; w < WAYS; w++) begin
         vals[w] = rd_row_ff[w*RRPV_W +: RRPV_W];
         inv[w]  = ~mask_wide[w];
      end
      for (int v = 0; v <= RRPV_MAX; v++) begin
         for (int w = 0; w < WAYS; w++) begin
            if (vals[w] == RRPV_W'(v)) begin
               present[v] = 1'b1;
            end
         end
      end
      for (int v = 0; v <= RRPV_MAX; v++) begin
         if (present[v]) begin
            top = RRPV_W'(v);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         at_top[w] = (vals[w] == top);
      end
      first_top = at_top & (~at_top + WAYS'(1));
      first_inv = inv & (~inv + WAYS'(1));
      // way numbers are reported modulo 16
      for (int w = 0; w < WAYS; w++) begin
         if (first_top[w]) begin
            top_way = top_way | drrip_pkg::WAY_INDEX_W'(w);
         end
         if (first_inv[w]) begin
            inv_way = inv_way | drrip_pkg::WAY_INDEX_W'(w);
         end
      end
   end

   always_comb begin
      sel_in         = sel_ff;
      rsp_payload_in = '0;
      for (int w = 0; w < WAYS; w++) begin
         new_vals[w] = vals[w];
      end
      new_row = rd_row_ff;
      unique case (req_ff.cmd)
         drrip_pkg::CMD_VICTIM: begin
            if (|inv) begin
               rsp_payload_in.victim_way         = inv_way;
               rsp_payload_in.victim_was_invalid = 1'b1;
            end else if (set_ok_ff) begin
               rsp_payload_in.victim_way = top_way;
               for (int w = 0; w < WAYS; w++) begin
                  new_vals[w] = vals[w] + (MAX_V - top);
               end
            end
         end
         drrip_pkg::CMD_FILL: begin
            if (set_ok_ff && way_ok) begin
               for (int w = 0; w < WAYS; w++) begin
                  if (32'(req_ff.way_index) == 32'(w)) begin
                     new_vals[w] = req_ff.is_write ? MAX_V : ins_val;
                  end
               end
               if (fill_brrip) begin
                  new_row[ROW_W-1 -: drrip_pkg::BIMODAL_W] = new_cnt;
               end
               if (!req_ff.is_write) begin
                  if (srrip_leader && sel_ff < SEL_TOP) begin
                     sel_in = sel_ff + SELECTOR_BITS'(1);
                  end else if (brrip_leader && sel_ff != '0) begin
                     sel_in = sel_ff - SELECTOR_BITS'(1);
                  end
               end
            end
         end
         drrip_pkg::CMD_ACCESS: begin
            if (set_ok_ff && way_ok && req_ff.is_hit && !req_ff.is_write) begin
               for (int w = 0; w < WAYS; w++) begin
                  if (32'(req_ff.way_index) == 32'(w)) begin
                     new_vals[w] = '0;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      for (int w = 0; w < WAYS; w++) begin
         new_row[w*RRPV_W +: RRPV_W] = new_vals[w];
      end
      rsp_payload_in.followers_use_srrip = (sel_in < SEL_MID);
   end

   // bit-serial remainder for a counter that outgrew a shortened period
   always_comb begin
      rem_shift  = {div_rem_ff[PW-2:0], div_num_ff[PW-1]};
      div_rem_in = (rem_shift >= period_eff) ? rem_shift - period_eff : rem_shift;
   end

   always_comb begin
      status.clear_last = (clr_cnt_ff == SET_W'(SETS - 1));
      status.need_div   = fill_brrip & slow & !div_valid_ff;
      status.div_last   = (div_cnt_ff == drrip_pkg::DIV_CNT_W'(drrip_pkg::DIV_STEPS - 1));
      status.out_busy   = rsp_valid_ff & rsp_stall;
   end

   always_comb begin
      mem_we = cmd.clear_step | (cmd.commit & set_ok_ff);
      mem_wa = cmd.clear_step ? clr_cnt_ff : set_addr_ff;
      mem_wd = cmd.clear_step ? CLEAR_ROW : new_row;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.accept) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff      <= req_payload;
         q_ff        <= prod[2*SIW-1:SIW];
         set_ok_ff   <= rd_ok;
         set_addr_ff <= rd_addr;
      end
      if (cmd.commit) begin
         rsp_payload_ff <= rsp_payload_in;
      end
      if (cmd.div_start) begin
         div_num_ff <= cnt_inc;
         div_rem_ff <= '0;
      end else if (cmd.div_step) begin
         div_num_ff <= div_num_ff << 1;
         div_rem_ff <= div_rem_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         sel_ff       <= SEL_MID;
         period_ff    <= drrip_pkg::PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
         div_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + SET_W'(1);
         end
         if (csr_write_enable) begin
            period_ff <= csr_write_data;
         end
         if (cmd.commit) begin
            sel_ff       <= sel_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.accept) begin
            div_valid_ff <= 1'b0;
         end else if (cmd.div_step && status.div_last) begin
            div_valid_ff <= 1'b1;
         end
         if (cmd.div_start) begin
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + drrip_pkg::DIV_CNT_W'(1);
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// File: rtl/drrip_cache_replacement.sv
// On accept a command's set row is read from RAM into a register; in the execute state the
// block ages, picks the victim and writes the row back while loading the result register.
// A new command is taken only after the current one has written back; write-back waits while a stalled result is held.
// A BRRIP fill whose incremented set counter reaches twice the period first runs a bit-serial remainder.
// After reset a clearing pass over all SETS rows (2048 by default) holds req_stall high;
// csr writes are taken throughout.
`default_nettype none

module drrip_cache_replacement #(
   parameter int SETS          = drrip_pkg::SETS_DEFAULT,
   parameter int WAYS          = drrip_pkg::WAYS_DEFAULT,
   parameter int LEADERS       = drrip_pkg::LEADERS_DEFAULT,
   parameter int SELECTOR_BITS = drrip_pkg::SELECTOR_BITS_DEFAULT,
   parameter int RRPV_MAX      = drrip_pkg::RRPV_MAX_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  drrip_pkg::req_payload_type      req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output drrip_pkg::rsp_payload_type      rsp_payload,
   input  logic                            csr_write_enable,
   input  logic [drrip_pkg::PERIOD_W-1:0]  csr_write_data
);

   drrip_pkg::ctrl_cmd_type    ctrl_cmd;
   drrip_pkg::ctrl_status_type ctrl_status;

   drrip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (ctrl_status),
      .cmd       (ctrl_cmd)
   );

   drrip_datapath #(
      .SETS          (SETS),
      .WAYS          (WAYS),
      .LEADERS       (LEADERS),
      .SELECTOR_BITS (SELECTOR_BITS),
      .RRPV_MAX      (RRPV_MAX)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (ctrl_cmd),
      .status           (ctrl_status)
   );

endmodule

`default_nettype wire

// File: rtl/drrip_checker.sv
// port-level checks for drrip_cache_replacement, attached by bind
// depends on drrip_pkg and drrip_cache_replacement_macros.svh
`default_nettype none
`include "drrip_cache_replacement_macros.svh"

module drrip_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input drrip_pkg::rsp_payload_type rsp_payload
);

   logic [1:0] pending_ff;
   logic [1:0] pending_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid & !req_stall;
   assign rsp_beat = rsp_valid & !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_beat && !req_beat) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // clearing pass follows every reset
   `DRRIP_ASSERT_IMPLIES(a_clear_after_reset, clock, reset, $past(reset), req_stall, "req taken during clearing pass")
   // one command in work at a time
   `DRRIP_ASSERT_NEXT(a_one_in_work, clock, reset, req_beat, req_stall, "back-to-back req beats")
   // every response belongs to an accepted command
   `DRRIP_ASSERT_IMPLIES(a_no_spurious_rsp, clock, reset, rsp_valid, pending_ff != 2'd0, "rsp without req")
   `DRRIP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled rsp changed")

endmodule

bind drrip_cache_replacement drrip_checker u_checker (.*);

`default_nettype wire
